FILE: hdl/sce_pkg.sv
// Shared types, constants and compare helpers for the symmetric codebook encoder.
// No dependencies; every other file in hdl/ depends on this package.
`default_nettype none

package sce_pkg;

  // Field widths fixed by the item format
  localparam int VAL_W  = 32;
  localparam int IDX_W  = 11;
  localparam int CODE_W = 12;
  localparam int CB_W   = 4;

  localparam logic [VAL_W-1:0] SIGN_MASK = 32'h8000_0000;
  localparam logic [VAL_W-1:0] MAG_MASK  = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] EXP_INF   = 32'h7F80_0000;

  // Request mode codes
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_STORE  = 1'b1;

  localparam logic [CB_W-1:0] CODE_BITS_RST = 4'd4;

  // One request as it travels down the search pipeline
  typedef struct packed {
    logic             valid;
    logic             mode;
    logic [VAL_W-1:0] x;
    logic [IDX_W-1:0] idx;
    logic             eov;
    logic [IDX_W-1:0] sub;
  } sce_item_t;

  function automatic logic is_nan(input logic [VAL_W-1:0] b);
    return (b & MAG_MASK) > EXP_INF;
  endfunction

  // IEEE test mag > bnd; mag is a non-negative, non-NaN magnitude
  function automatic logic mag_greater(input logic [VAL_W-1:0] mag,
                                       input logic [VAL_W-1:0] bnd);
    logic res;
    if (is_nan(bnd)) begin
      res = 1'b0;
    end else if ((bnd & SIGN_MASK) != '0) begin
      res = !(mag == '0 && (bnd & MAG_MASK) == '0);
    end else begin
      res = mag > bnd;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sce_if.sv
// Valid/ready channel interfaces for the encoder's request and result streams.
// Depends on sce_pkg for field widths.
`default_nettype none

interface sce_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [sce_pkg::VAL_W-1:0]   value_bits;
  logic [sce_pkg::IDX_W-1:0]   table_index;
  logic                        end_of_vector;

  modport source (output valid, mode, value_bits, table_index, end_of_vector,
                  input ready);
  modport sink   (input valid, mode, value_bits, table_index, end_of_vector,
                  output ready);
endinterface

interface sce_out_if;
  logic                        valid;
  logic                        ready;
  logic [sce_pkg::CODE_W-1:0]  code;
  logic                        last_code;

  modport source (output valid, code, last_code, input ready);
  modport sink   (input valid, code, last_code, output ready);
endinterface

`default_nettype wire

FILE: hdl/sce_level.sv
// One binary search level: the boundary bank this level probes plus its stage register.
// Depends on sce_pkg.
`default_nettype none

module sce_level #(
  parameter int LV    = 11,
  parameter int LEVEL = 0
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      adv,
  input  wire [sce_pkg::CB_W-1:0]  bits_eff,
  input  sce_pkg::sce_item_t       item_i,
  output sce_pkg::sce_item_t       item_o
);
  import sce_pkg::*;

  localparam int AW    = (LEVEL == 0) ? 1 : LEVEL;
  localparam int DEPTH = 1 << AW;
  localparam int SH    = LV - 1 - LEVEL;
  localparam logic [IDX_W-1:0] STEP = IDX_W'(1 << SH);
  localparam logic [IDX_W-1:0] MASK = IDX_W'((1 << (SH + 1)) - 1);
  localparam logic [IDX_W-1:0] PAT  = IDX_W'((1 << SH) - 1);
  localparam logic [5:0]       ACT_MIN = 6'(LV + 1 - LEVEL);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] bnd_r;
  sce_item_t        item_r;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic             wr_hit;
  logic             active;
  logic             gt;

  // Bank address: the top LEVEL bits of the running sub-code or the store index
  if (LEVEL == 0) begin : g_addr0
    assign rd_addr = '0;
    assign wr_addr = '0;
  end else begin : g_addr
    assign rd_addr = item_i.sub[LV-1 -: LEVEL];
    assign wr_addr = item_i.idx[LV-1 -: LEVEL];
  end

  // A store lands in this bank when its index is a probe point of this level
  assign wr_hit = item_i.valid && (item_i.mode == MODE_STORE)
                  && ((item_i.idx >> LV) == '0)
                  && ((item_i.idx & MASK) == PAT);

  // Write stores and register the probed boundary, both in request order
  always_ff @(posedge clk) begin
    if (adv) begin
      if (wr_hit) begin
        mem[wr_addr] <= item_i.x;
      end
      bnd_r <= mem[rd_addr];
    end
  end

  // Hold the request beside its boundary
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else if (adv) begin
      item_r <= item_i;
    end
  end

  // Skip levels above the configured code size; NaN never moves
  assign active = !is_nan(item_r.x) && (6'(bits_eff) >= ACT_MIN);
  assign gt     = mag_greater(item_r.x & MAG_MASK, bnd_r);

  always_comb begin
    item_o = item_r;
    if (active && gt) begin
      item_o.sub = item_r.sub | STEP;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sce_out.sv
// Sign fold and result register with the pipeline advance control.
// Depends on sce_pkg and sce_out_if.
`default_nettype none

module sce_out (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire [sce_pkg::CB_W-1:0]  bits_eff,
  input  sce_pkg::sce_item_t       item_i,
  output logic                     adv,
  sce_out_if.source                res
);
  import sce_pkg::*;

  logic              out_valid_r;
  logic [CODE_W-1:0] code_r;
  logic              last_r;
  logic [CODE_W-1:0] half;
  logic [CODE_W-1:0] sub_ext;
  logic              nonneg;
  logic [CODE_W-1:0] code_nxt;

  // Advance the whole pipeline unless a result waits here
  assign adv = !out_valid_r || res.ready;

  // Fold the sign back around the middle of the codebook
  assign half     = CODE_W'(1) << (bits_eff - CB_W'(1));
  assign sub_ext  = CODE_W'(item_i.sub);
  assign nonneg   = !is_nan(item_i.x)
                    && (((item_i.x & SIGN_MASK) == '0) || ((item_i.x & MAG_MASK) == '0));
  assign code_nxt = nonneg ? (half + sub_ext) : (half - CODE_W'(1) - sub_ext);

  // Drop stores; register encodes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= item_i.valid && (item_i.mode == MODE_ENCODE);
      code_r      <= code_nxt;
      last_r      <= item_i.eov;
    end
  end

  assign res.valid     = out_valid_r;
  assign res.code      = code_r;
  assign res.last_code = last_r;

endmodule

`default_nettype wire

FILE: hdl/symmetric_codebook_encoder.sv
// Pipeline: a request passes the input register, LV search levels (MAX_BITS-1 when
// MAX_BITS is 2 or more) and the result register.
// Throughput: one request per cycle while the output is not stalled; each search level
// owns its boundary bank, so every level reads once per cycle. Any output stall freezes all stages.
// Reset: synchronous, active low; clears valid bits and sets code_bits to 4, clamped to MAX_BITS.
// Boundary banks are not cleared. Depends on sce_pkg, sce_if, sce_level, sce_out.
`default_nettype none

module symmetric_codebook_encoder #(
  parameter int MAX_BITS = 12
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      cfg_we,
  input  wire [sce_pkg::CB_W-1:0]  cfg_wdata,
  sce_in_if.sink                   in_req,
  sce_out_if.source                out_res
);
  import sce_pkg::*;

  localparam int LV = (MAX_BITS < 2) ? 1 : MAX_BITS - 1;
  localparam logic [CB_W-1:0] MAXB = CB_W'(MAX_BITS);

  logic [CB_W-1:0] bits_eff_r;
  logic [CB_W-1:0] bits_eff_nxt;
  logic            adv;
  sce_item_t       s0_r;
  sce_item_t       lvl_item [LV+1];

  // Clamp the code size on write
  always_comb begin
    if (cfg_wdata == '0) begin
      bits_eff_nxt = CB_W'(1);
    end else if (cfg_wdata > MAXB) begin
      bits_eff_nxt = MAXB;
    end else begin
      bits_eff_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_eff_r <= (CODE_BITS_RST > MAXB) ? MAXB : CODE_BITS_RST;
    end else if (cfg_we) begin
      bits_eff_r <= bits_eff_nxt;
    end
  end

  // Register the incoming request
  assign in_req.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.valid <= 1'b0;
    end else if (adv) begin
      s0_r.valid <= in_req.valid;
      s0_r.mode  <= in_req.mode;
      s0_r.x     <= in_req.value_bits;
      s0_r.idx   <= in_req.table_index;
      s0_r.eov   <= in_req.end_of_vector;
      s0_r.sub   <= '0;
    end
  end

  assign lvl_item[0] = s0_r;

  // One stage per search level
  for (genvar j = 0; j < LV; j++) begin : g_lvl
    sce_level #(
      .LV    (LV),
      .LEVEL (j)
    ) u_level (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .bits_eff (bits_eff_r),
      .item_i   (lvl_item[j]),
      .item_o   (lvl_item[j+1])
    );
  end

  sce_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .bits_eff (bits_eff_r),
    .item_i   (lvl_item[LV]),
    .adv      (adv),
    .res      (out_res)
  );

  // Clamped code size stays in its legal range
  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    (bits_eff_r >= CB_W'(1)) && (bits_eff_r <= MAXB))
    else $error("code size register out of range");

  // A store leaving the last level never shows up as a result
  a_store_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && lvl_item[LV].valid && (lvl_item[LV].mode == MODE_STORE)) |=> !out_res.valid)
    else $error("store request produced a result");

  // A stall freezes the input stage
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !adv) |=> $stable(s0_r))
    else $error("input stage moved during a stall");

endmodule

`default_nettype wire

FILE: bench/symmetric_codebook_encoder_chk.sv
// Scoreboard for the symmetric codebook encoder: watches the request, result and
// register ports, predicts each code and compares it with what the block returns.
// Depends on sce_pkg and the channel interfaces in sce_if.
module symmetric_codebook_encoder_chk (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [sce_pkg::CB_W-1:0] cfg_wdata,
  sce_in_if                        req_mon,
  sce_out_if                       res_mon,
  output int                       err_count,
  output int                       pending,
  output int                       codes_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import sce_pkg::*;

  localparam int MAX_BITS = 12;
  localparam int DEPTH    = 1 << IDX_W;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last_code;
  } code_exp_t;

  logic [VAL_W-1:0] boundary_img [DEPTH];
  logic [CB_W-1:0]  code_bits_q;
  code_exp_t        expected_codes [$];

  // Strict IEEE greater-than of a non-negative magnitude over one boundary word
  function automatic logic beats_bound(input logic [VAL_W-1:0] mag,
                                       input logic [VAL_W-1:0] bnd);
    logic [VAL_W-1:0] bmag;
    bmag = bnd & MAG_MASK;
    if (bmag > EXP_INF) return 1'b0;
    if (bnd[VAL_W-1]) return !(mag == '0 && bmag == '0);
    return mag > bnd;
  endfunction

  // Binary search over the boundary image, then fold the sign back in
  function automatic logic [CODE_W-1:0] quantize(input logic [VAL_W-1:0] x,
                                                 input logic [CB_W-1:0] cb);
    int unsigned      bits, half, stp, sub;
    logic [VAL_W-1:0] mag;
    logic             nan, nonneg;
    bits = cb;
    if (bits < 1) bits = 1;
    if (bits > MAX_BITS) bits = MAX_BITS;
    half = 1 << (bits - 1);
    mag  = x & MAG_MASK;
    nan  = mag > EXP_INF;
    sub  = 0;
    if (!nan) begin
      for (stp = half >> 1; stp > 0; stp = stp >> 1) begin
        if (beats_bound(mag, boundary_img[(sub + stp - 1) % DEPTH])) sub += stp;
      end
    end
    nonneg = !nan && (!x[VAL_W-1] || mag == '0);
    return nonneg ? CODE_W'(half + sub) : CODE_W'(half - 1 - sub);
  endfunction

  always @(posedge clk) begin : track
    code_exp_t want;
    if (!rst_n) begin
      code_bits_q   = CODE_BITS_RST;
      err_count     = 0;
      codes_checked = 0;
      expected_codes.delete();
    end else begin
      if (cfg_we) code_bits_q = cfg_wdata;

      // Apply a store or queue the prediction for an encode
      if (req_mon.valid && req_mon.ready) begin
        if (req_mon.mode == MODE_STORE) begin
          boundary_img[req_mon.table_index] = req_mon.value_bits;
        end else begin
          want.code      = quantize(req_mon.value_bits, code_bits_q);
          want.last_code = req_mon.end_of_vector;
          expected_codes.push_back(want);
        end
      end

      // Compare each returned code with the oldest prediction
      if (res_mon.valid && res_mon.ready) begin
        if (expected_codes.size() == 0) begin
          $error("unexpected result: code %0d with no encode pending", res_mon.code);
          err_count++;
        end else begin
          want = expected_codes.pop_front();
          codes_checked++;
          if (res_mon.code !== want.code) begin
            $error("code: expected %0d, got %0d", want.code, res_mon.code);
            err_count++;
          end
          if (res_mon.last_code !== want.last_code) begin
            $error("last_code: expected %0d, got %0d", want.last_code, res_mon.last_code);
            err_count++;
          end
        end
      end
    end
    pending = expected_codes.size();
  end

endmodule

FILE: bench/symmetric_codebook_encoder_tb.sv
// Top of the encoder bench: clock, reset, request and register stimulus, result
// back-pressure, watchdog and verdict. Checking lives in symmetric_codebook_encoder_chk.
// Depends on sce_pkg, sce_if and the encoder RTL.
module symmetric_codebook_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sce_pkg::*;

  localparam int MAX_BITS       = 12;
  localparam int DEPTH          = 1 << IDX_W;
  localparam int SETTLE         = MAX_BITS + 8;
  localparam int IDLE_LIMIT     = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int RAND_PER_PHASE = 60;
  localparam int WINDOW_CELLS   = 16;
  localparam int N_PLAN         = 16;

  localparam logic [VAL_W-1:0] DIR_BND [7] = '{
    32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h4080_0000,
    32'h40A0_0000, 32'h40C0_0000, 32'h40E0_0000};
  localparam logic [VAL_W-1:0] DIR_VAL [13] = '{
    32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h3F80_0001,
    32'h40F0_0000, 32'hC0F0_0000, 32'h7F80_0000, 32'hFF80_0000,
    32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h0000_0001,
    32'h8000_0001};
  localparam logic [VAL_W-1:0] SPECIALS [12] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
    32'h7FC0_0000, 32'hFFC0_0000, 32'h7F80_0001, 32'h0000_0001,
    32'h8000_0001, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7FFF_FFFF};

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [CB_W-1:0] cfg_wdata;
  int              err_count, pending, codes_checked;

  sce_in_if  req_ch();
  sce_out_if res_ch();

  symmetric_codebook_encoder #(.MAX_BITS(MAX_BITS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_req   (req_ch.sink),
    .out_res  (res_ch.source)
  );

  symmetric_codebook_encoder_chk chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .req_mon      (req_ch),
    .res_mon      (res_ch),
    .err_count    (err_count),
    .pending      (pending),
    .codes_checked(codes_checked)
  );

  // Sender bookkeeping: what has been stored, so no encode probes a blank entry
  logic [VAL_W-1:0] table_img [DEPTH];
  bit               written [DEPTH];
  int               burst_left, n_enc, n_store;
  int unsigned      lo_m, hi_m;
  int unsigned      grid_base, grid_pitch;
  int               win_lo, win_n, cur_bits;
  bit               pressure_req;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Offer one request in bursts with random gaps; return at a falling edge
  task automatic send_request(input logic mode, input logic [VAL_W-1:0] val,
                              input logic [IDX_W-1:0] idx, input logic eov);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
    end
    req_ch.valid         <= 1'b1;
    req_ch.mode          <= mode;
    req_ch.value_bits    <= val;
    req_ch.table_index   <= idx;
    req_ch.end_of_vector <= eov;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    burst_left--;
    if (mode == MODE_STORE) begin
      table_img[idx] = val;
      written[idx]   = 1'b1;
      n_store++;
    end else begin
      n_enc++;
    end
    @(negedge clk);
  endtask

  task automatic store_boundary(input int idx, input logic [VAL_W-1:0] val);
    send_request(MODE_STORE, val, idx[IDX_W-1:0], 1'($urandom_range(0, 1)));
  endtask

  // Ascending boundary for entry ix on the current grid
  function automatic logic [VAL_W-1:0] grid_value(input int ix);
    return grid_base + grid_pitch * ix + $urandom_range(grid_pitch - 1, 0);
  endfunction

  // Store every boundary the coming search reaches that is still blank
  task automatic fill_path(input logic [VAL_W-1:0] val);
    int               stp, sub, ix;
    logic [VAL_W-1:0] mag;
    mag = val & MAG_MASK;
    if (mag <= EXP_INF) begin
      sub = 0;
      for (stp = (1 << (cur_bits - 1)) >> 1; stp > 0; stp = stp >> 1) begin
        ix = sub + stp - 1;
        if (!written[ix]) store_boundary(ix, grid_value(ix));
        if (mag_greater(mag, table_img[ix])) sub += stp;
      end
    end
  endtask

  task automatic encode_value(input logic [VAL_W-1:0] val, input logic eov);
    fill_path(val);
    send_request(MODE_ENCODE, val, IDX_W'($urandom_range(DEPTH - 1, 0)), eov);
  endtask

  // Drain the block, let in-flight stores settle, then write the register
  task automatic set_code_bits(input logic [CB_W-1:0] v);
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Pick a fresh ascending grid and a window of cells the in-range values land in
  task automatic set_grid(input int n);
    grid_base  = $urandom_range(32'h3F00_0000, 32'h3A00_0000);
    grid_pitch = $urandom_range(32'h0002_0000, 1);
    win_n      = (n < WINDOW_CELLS) ? n + 1 : WINDOW_CELLS;
    win_lo     = $urandom_range(n + 1 - win_n, 0);
    lo_m       = grid_base + grid_pitch * win_lo - 2 * grid_pitch;
    hi_m       = grid_base + grid_pitch * (win_lo + win_n + 1);
  endtask

  // Mostly in-window magnitudes and near-boundary values, some specials and noise
  function automatic logic [VAL_W-1:0] pick_value(input int n);
    logic [VAL_W-1:0] v;
    int               k, j;
    k = $urandom_range(0, 99);
    j = win_lo + int'($urandom_range(win_n - 1, 0));
    if (j > n - 1) j = n - 1;
    if (k >= 55 && k < 75 && n > 0 && written[j]) begin
      v = table_img[j] + $urandom_range(2, 0) - 1;
    end else if (k < 75) begin
      v = $urandom_range(hi_m, lo_m);
    end else if (k < 85) begin
      v = SPECIALS[$urandom_range(11, 0)];
    end else begin
      v = $urandom;
    end
    if (k < 75) v[VAL_W-1] = $urandom_range(0, 1);
    return v;
  endfunction

  // Random phase: encodes with some stores anywhere in the table
  task automatic run_random(input int n, input int count);
    int               k;
    logic [VAL_W-1:0] v;
    repeat (count) begin
      k = $urandom_range(0, 99);
      if (k < 12) begin
        v = (k < 6) ? $urandom : $urandom_range(hi_m, lo_m);
        store_boundary($urandom_range(DEPTH - 1, 0), v);
      end else begin
        encode_value(pick_value(n), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Result back-pressure: changing stall patterns plus one long hold-off
  initial begin : receiver
    int kind, stretch_left, hold_left, tick;
    bit pressure_done;
    kind          = 0;
    stretch_left  = 0;
    hold_left     = 0;
    tick          = 0;
    pressure_done = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (pressure_req && !pressure_done) begin
        pressure_done = 1'b1;
        hold_left     = HOLD_CYCLES - 1;
        res_ch.ready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          kind         = $urandom_range(0, 3);
          stretch_left = $urandom_range(20, 200);
        end
        stretch_left--;
        case (kind)
          0: begin
            res_ch.ready <= 1'b1;
          end
          1: begin
            res_ch.ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            res_ch.ready <= (tick % 3) != 0;
          end
          default: begin
            res_ch.ready <= ($urandom_range(0, 9) < 3);
          end
        endcase
      end
    end
  end

  // End the run when nothing moves on either channel for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) idle = 0;
      else idle++;
    end
    $display("symmetric_codebook_encoder_tb: errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned plan [N_PLAN];
    int          eff, n;
    plan = '{4, 1, 0, 2, 3, 5, 6, 7, 8, 12, 15, 13, 11, 10, 9, 14};
    burst_left = 0;
    n_enc      = 0;
    n_store    = 0;
    cur_bits   = CODE_BITS_RST;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    req_ch.valid         <= 1'b0;
    req_ch.mode          <= MODE_ENCODE;
    req_ch.value_bits    <= '0;
    req_ch.table_index   <= '0;
    req_ch.end_of_vector <= 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, at the reset width: signed zeros, equality, infinities, NaNs
    for (int i = 0; i < 7; i++) store_boundary(i, DIR_BND[i]);
    for (int i = 0; i < 13; i++) encode_value(DIR_VAL[i], 1'(i));
    // NaN, negative zero and negative boundaries inside the table
    store_boundary(3, 32'h7FC0_0000);
    store_boundary(1, 32'h8000_0000);
    store_boundary(5, 32'hC000_0000);
    encode_value(32'h4020_0000, 1'b1);
    encode_value(32'h0000_0000, 1'b0);
    encode_value(32'h8000_0000, 1'b1);

    // Sweep the register; each setting gets a fresh grid, filled as searches reach it
    for (int p = 0; p < N_PLAN; p++) begin
      set_code_bits(plan[p][CB_W-1:0]);
      eff      = (plan[p] == 0) ? 1 : (plan[p] > MAX_BITS) ? MAX_BITS : plan[p];
      n        = (1 << (eff - 1)) - 1;
      cur_bits = eff;
      set_grid(n);
      if (p == 7) pressure_req = 1'b1;
      run_random(n, RAND_PER_PHASE);
    end

    // Drain and give any stray result time to show up
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("ran %0d requests (%0d encodes, %0d boundary stores), %0d codes compared",
             n_enc + n_store, n_enc, n_store, codes_checked);
    $display("code_bits swept over %0d settings from 0 to 15, one %0d-cycle output hold-off",
             N_PLAN, HOLD_CYCLES);
    if (err_count == 0 && pending == 0) begin
      $display("symmetric_codebook_encoder_tb: clean");
    end else begin
      $display("symmetric_codebook_encoder_tb: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/sce_pkg.sv
hdl/sce_if.sv
hdl/sce_level.sv
hdl/sce_out.sv
hdl/symmetric_codebook_encoder.sv
bench/symmetric_codebook_encoder_chk.sv
bench/symmetric_codebook_encoder_tb.sv
